>>> rtl/transient_gain_computer_assert.svh
// assertion macros for the transient gain computer
`ifndef TRANSIENT_GAIN_COMPUTER_ASSERT_SVH
`define TRANSIENT_GAIN_COMPUTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TGC_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TGC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/tgc_pkg.sv
`default_nettype none

package tgc_pkg;

    localparam int NUM_CHANNELS_DEF    = 2;
    localparam int LOG_TABLE_DEPTH_DEF = 256;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_PUNCH = 2'd0;
    localparam logic [1:0] REG_RISE  = 2'd1;
    localparam logic [1:0] REG_FALL  = 2'd2;

    localparam logic [15:0] ONE_Q13     = 16'd8192;
    localparam logic [16:0] GAIN_MAX    = 17'd32768;
    localparam logic [16:0] GAIN_MIN    = 17'd4096;
    localparam logic [13:0] SCALE_MIN   = 14'd4096;
    localparam logic [13:0] SCALE_MAX   = 14'd12288;
    localparam logic [15:0] ENV_THRESH  = 16'd410;
    localparam logic [15:0] NOISE_FLOOR = 16'd4;
    localparam logic [16:0] LOG_OFFSET  = 17'd41;
    localparam logic [16:0] CUT_FACTOR  = 17'd19661;
    localparam logic [16:0] LOG10_OF_2  = 17'd19728;
    localparam logic [14:0] HALF_BIAS   = 15'd9864;
    localparam logic [14:0] SCALE_BASE  = 15'(ONE_Q13) + HALF_BIAS;
    localparam logic [14:0] H_LOW_CLIP  = SCALE_BASE - 15'(SCALE_MIN);
    localparam logic [14:0] H_HIGH_CLIP = SCALE_BASE - 15'(SCALE_MAX);
    localparam logic [16:0] UNITY_Q16   = 17'h10000;

    localparam int STEP_W    = 5;
    localparam int NUM_STEPS = 20;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [4:0] {
        U_LOAD,
        U_MUL_DELTA,
        U_ATTACK,
        U_MUL_RISE,
        U_RISE,
        U_MUL_FALL,
        U_FALL,
        U_MUL_SP,
        U_MUL_CUT,
        U_CUT,
        U_MUL_GAIN,
        U_GAIN,
        U_NORM,
        U_INDEX,
        U_LOOKUP,
        U_MUL_LOG,
        U_SCALE,
        U_MUL_MIX,
        U_MIX,
        U_UNITY
    } uop_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_RISE,
        C_BELOW,
        C_NOISE
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
        logic  last;
    } ucode_t;

    localparam step_t S_SUSTAIN = 5'd3;
    localparam step_t S_DECAY   = 5'd5;
    localparam step_t S_CUT     = 5'd7;
    localparam step_t S_UNITY   = 5'd19;

    localparam ucode_t UCODE [NUM_STEPS] = '{
        '{U_LOAD,      C_NO_RISE, S_SUSTAIN, 1'b0},
        '{U_MUL_DELTA, C_NONE,    '0,        1'b0},
        '{U_ATTACK,    C_NONE,    '0,        1'b0},
        '{U_MUL_RISE,  C_BELOW,   S_DECAY,   1'b0},
        '{U_RISE,      C_ALWAYS,  S_CUT,     1'b0},
        '{U_MUL_FALL,  C_NONE,    '0,        1'b0},
        '{U_FALL,      C_NONE,    '0,        1'b0},
        '{U_MUL_SP,    C_NONE,    '0,        1'b0},
        '{U_MUL_CUT,   C_NONE,    '0,        1'b0},
        '{U_CUT,       C_NONE,    '0,        1'b0},
        '{U_MUL_GAIN,  C_NONE,    '0,        1'b0},
        '{U_GAIN,      C_NOISE,   S_UNITY,   1'b0},
        '{U_NORM,      C_NONE,    '0,        1'b0},
        '{U_INDEX,     C_NONE,    '0,        1'b0},
        '{U_LOOKUP,    C_NONE,    '0,        1'b0},
        '{U_MUL_LOG,   C_NONE,    '0,        1'b0},
        '{U_SCALE,     C_NONE,    '0,        1'b0},
        '{U_MUL_MIX,   C_NONE,    '0,        1'b0},
        '{U_MIX,       C_NONE,    '0,        1'b1},
        '{U_UNITY,     C_NONE,    '0,        1'b1}
    };

    // log2 fraction of a Q2.30 mantissa by repeated squaring, elaboration only
    function automatic logic [15:0] log_frac(input logic [63:0] y0);
        logic [63:0] y;
        logic [15:0] frac;
        y    = y0;
        frac = '0;
        for (int b = 0; b < 16; b++)
        begin
            y    = (y * y) >> 30;
            frac = {frac[14:0], 1'b0};
            if (y >= (64'd2 << 30))
            begin
                y       = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return frac;
    endfunction

    function automatic logic [4:0] msb17(input logic [16:0] v);
        logic [4:0] k;
        k = '0;
        for (int i = 0; i < 17; i++)
        begin
            if (v[i])
            begin
                k = 5'(i);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/transient_gain_computer.sv
// the time from an accepted request to out_valid is set by the
// microprogram path (no rise below the noise floor is shortest, rising attack plus decay longest)
// one request at a time; one shared 32x17 multiplier, one microcode step per cycle
// while the last step is not held by out_stall; a new request is taken once the program ends
// reset: rst_n clears registers, per-channel envelope state and control at once
`default_nettype none

module transient_gain_computer
    import tgc_pkg::*;
#(
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              chan,
    input  wire logic [15:0]       env_level,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [15:0]            gain,
    output logic [13:0]            detail_scale,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDX_W  = $clog2(LOG_TABLE_DEPTH);
    localparam int SPAN_W = 17 + IDX_W + 1;

    // log2(1 + i/depth) table, built at elaboration
    logic [15:0] log_rom [LOG_TABLE_DEPTH];

    for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam logic [63:0] Y0 =
            ((64'(LOG_TABLE_DEPTH) + 64'(gi)) << 30) / 64'(LOG_TABLE_DEPTH);
        assign log_rom[gi] = log_frac(Y0);
    end

    logic [15:0] punch_reg, rise_reg, fall_reg;
    logic [15:0] last_env_reg    [NUM_CHANNELS];
    logic [15:0] sustain_env_reg [NUM_CHANNELS];

    logic        busy_reg, busy_next;
    step_t       step_reg, step_next;
    logic        out_valid_reg, out_valid_next;

    logic [CH_W-1:0] chan_reg, chan_next;
    logic [15:0] env_reg, env_next;
    logic [15:0] prev_reg, prev_next;
    logic [15:0] s_reg, s_next;
    logic [15:0] attack_reg, attack_next;
    logic [13:0] sg_reg, sg_next;
    logic [15:0] gain_res_reg, gain_res_next;
    logic [16:0] x_reg, x_next;
    logic [4:0]  k_reg, k_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [19:0] p_reg, p_next;
    logic [13:0] scale_reg, scale_next;
    logic [48:0] prod_reg, prod_next;
    logic [15:0] gain_out_reg, gain_out_next;
    logic [13:0] detail_out_reg, detail_out_next;

    ucode_t      word;
    logic        in_accept, hold, jump;
    logic        wr_last, wr_sus;
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_p;
    logic [CH_W-1:0] chan_sel;
    logic        cfg_write;

    logic [21:0] boost;
    logic [22:0] attack_sum;
    logic [16:0] rise_step;
    logic [17:0] rise_sum;
    logic [32:0] fall_sum;
    logic [47:0] cut_sum;
    logic [29:0] gain_sum;
    logic [16:0] gain_q;
    logic [16:0] x_val;
    logic [16:0] span_diff;
    logic [SPAN_W-1:0] span;
    logic [14:0] half_val;
    logic [31:0] mix_sum;
    logic [13:0] detail_val;

    assign word      = UCODE[step_reg];
    assign in_stall  = busy_reg;
    assign in_accept = in_valid && !busy_reg;
    assign hold      = busy_reg && word.last && out_valid_reg && out_stall;
    assign mul_p     = 49'(mul_a) * 49'(mul_b);
    assign chan_sel  = (NUM_CHANNELS == 1) ? '0 : CH_W'(chan);

    assign out_valid    = out_valid_reg;
    assign gain         = gain_out_reg;
    assign detail_scale = detail_out_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite;

    // register file
    always_comb
    begin
        case (paddr[3:2])
            REG_PUNCH: prdata = DATA_W'(punch_reg);
            REG_RISE:  prdata = DATA_W'(rise_reg);
            REG_FALL:  prdata = DATA_W'(fall_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            punch_reg <= '0;
            rise_reg  <= '0;
            fall_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_PUNCH: punch_reg <= pwdata[15:0];
                REG_RISE:  rise_reg  <= pwdata[15:0];
                REG_FALL:  fall_reg  <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        case (word.cond)
            C_ALWAYS:  jump = 1'b1;
            C_NO_RISE: jump = (env_reg <= last_env_reg[chan_reg]);
            C_BELOW:   jump = (env_reg < ENV_THRESH);
            C_NOISE:   jump = (env_reg <= NOISE_FLOOR);
            default:   jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg && !hold)
        begin
            if (word.last)
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else if (jump)
            begin
                step_next = word.target;
            end
            else
            begin
                step_next = step_reg + step_t'(1);
            end
        end
    end

    // datapath
    always_comb
    begin
        chan_next       = chan_reg;
        env_next        = env_reg;
        prev_next       = prev_reg;
        s_next          = s_reg;
        attack_next     = attack_reg;
        sg_next         = sg_reg;
        gain_res_next   = gain_res_reg;
        x_next          = x_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        p_next          = p_reg;
        scale_next      = scale_reg;
        prod_next       = prod_reg;
        gain_out_next   = gain_out_reg;
        detail_out_next = detail_out_reg;
        wr_last         = 1'b0;
        wr_sus          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        boost      = 22'((({5'b0, prod_reg[31:0]} << 4) + ({5'b0, prod_reg[31:0]} << 2)
                     + 37'd16384) >> 15);
        attack_sum = 23'(ONE_Q13) + 23'(boost);
        rise_step  = 17'((33'(prod_reg[31:0]) + 33'd32768) >> 16);
        rise_sum   = 18'(s_reg) + 18'(rise_step);
        fall_sum   = 33'(prod_reg[31:0]) + 33'd32768;
        cut_sum    = prod_reg[47:0] + (48'd1 << 34);
        gain_sum   = 30'(prod_reg[28:0]) + 30'd4096;
        gain_q     = gain_sum[29:13];
        x_val      = 17'(env_reg) + LOG_OFFSET;
        span_diff  = x_reg - (17'd1 << k_reg);
        span       = SPAN_W'(span_diff) * SPAN_W'(LOG_TABLE_DEPTH);
        half_val   = prod_reg[34:20];
        mix_sum    = 32'(prod_reg[29:0]) + {2'b0, UNITY_Q16 - 17'(punch_reg), 13'b0}
                     + 32'd32768;
        detail_val = (word.op == U_UNITY) ? 14'(ONE_Q13) : mix_sum[29:16];

        if (in_accept)
        begin
            chan_next = chan_sel;
            env_next  = env_level;
        end
        else if (busy_reg)
        begin
            case (word.op)
                U_LOAD:
                begin
                    prev_next   = last_env_reg[chan_reg];
                    s_next      = sustain_env_reg[chan_reg];
                    attack_next = ONE_Q13;
                    wr_last     = 1'b1;
                end
                U_MUL_DELTA:
                begin
                    mul_a     = 32'(env_reg - prev_reg);
                    mul_b     = 17'(punch_reg);
                    prod_next = mul_p;
                end
                U_ATTACK:
                begin
                    attack_next = (attack_sum > 23'(GAIN_MAX)) ? 16'(GAIN_MAX)
                                                              : attack_sum[15:0];
                end
                U_MUL_RISE:
                begin
                    mul_a     = 32'(rise_reg);
                    mul_b     = UNITY_Q16 - 17'(s_reg);
                    prod_next = mul_p;
                end
                U_RISE:
                begin
                    s_next = (rise_sum > 18'd65535) ? 16'hFFFF : rise_sum[15:0];
                end
                U_MUL_FALL:
                begin
                    mul_a     = 32'(UNITY_Q16 - 17'(fall_reg));
                    mul_b     = 17'(s_reg);
                    prod_next = mul_p;
                end
                U_FALL:
                begin
                    s_next = fall_sum[31:16];
                end
                U_MUL_SP:
                begin
                    wr_sus    = 1'b1;
                    mul_a     = 32'(s_reg);
                    mul_b     = 17'(punch_reg);
                    prod_next = mul_p;
                end
                U_MUL_CUT:
                begin
                    mul_a     = prod_reg[31:0];
                    mul_b     = CUT_FACTOR;
                    prod_next = mul_p;
                end
                U_CUT:
                begin
                    sg_next = 14'(ONE_Q13) - 14'(cut_sum[47:35]);
                end
                U_MUL_GAIN:
                begin
                    mul_a     = 32'(attack_reg);
                    mul_b     = 17'(sg_reg);
                    prod_next = mul_p;
                end
                U_GAIN:
                begin
                    if (gain_q > GAIN_MAX)
                    begin
                        gain_res_next = 16'(GAIN_MAX);
                    end
                    else if (gain_q < GAIN_MIN)
                    begin
                        gain_res_next = 16'(GAIN_MIN);
                    end
                    else
                    begin
                        gain_res_next = gain_q[15:0];
                    end
                end
                U_NORM:
                begin
                    x_next = x_val;
                    k_next = msb17(x_val);
                end
                U_INDEX:
                begin
                    idx_next = IDX_W'(span >> k_reg);
                end
                U_LOOKUP:
                begin
                    p_next = {4'(k_reg - 5'd4), log_rom[idx_reg]};
                end
                U_MUL_LOG:
                begin
                    mul_a     = 32'(p_reg);
                    mul_b     = LOG10_OF_2;
                    prod_next = mul_p;
                end
                U_SCALE:
                begin
                    if (half_val > H_LOW_CLIP)
                    begin
                        scale_next = SCALE_MIN;
                    end
                    else if (half_val < H_HIGH_CLIP)
                    begin
                        scale_next = SCALE_MAX;
                    end
                    else
                    begin
                        scale_next = 14'(SCALE_BASE - half_val);
                    end
                end
                U_MUL_MIX:
                begin
                    mul_a     = 32'(scale_reg);
                    mul_b     = 17'(punch_reg);
                    prod_next = mul_p;
                end
                U_MIX, U_UNITY:
                begin
                    if (!hold)
                    begin
                        gain_out_next   = gain_res_reg;
                        detail_out_next = detail_val;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                last_env_reg[c]    <= '0;
                sustain_env_reg[c] <= '0;
            end
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (wr_last)
            begin
                last_env_reg[chan_reg] <= env_reg;
            end
            if (wr_sus)
            begin
                sustain_env_reg[chan_reg] <= s_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg       <= chan_next;
        env_reg        <= env_next;
        prev_reg       <= prev_next;
        s_reg          <= s_next;
        attack_reg     <= attack_next;
        sg_reg         <= sg_next;
        gain_res_reg   <= gain_res_next;
        x_reg          <= x_next;
        k_reg          <= k_next;
        idx_reg        <= idx_next;
        p_reg          <= p_next;
        scale_reg      <= scale_next;
        prod_reg       <= prod_next;
        gain_out_reg   <= gain_out_next;
        detail_out_reg <= detail_out_next;
    end

endmodule

`default_nettype wire

>>> rtl/tgc_checker.sv
`default_nettype none

`include "transient_gain_computer_assert.svh"

module tgc_checker
    import tgc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] gain,
    input wire logic [13:0] detail_scale
);

    // a stalled result stays put
    `TGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(gain) && $stable(detail_scale), "stalled result changed")

    // one request at a time
    `TGC_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall,
        in_stall && !$rose(out_valid), "request taken while busy or result too early")

    `TGC_ASSERT_SAME(a_gain_range, out_valid,
        17'(gain) >= GAIN_MIN && 17'(gain) <= GAIN_MAX, "gain out of range")

    `TGC_ASSERT_SAME(a_detail_range, out_valid,
        detail_scale >= SCALE_MIN && detail_scale <= SCALE_MAX, "detail scale out of range")

endmodule

bind transient_gain_computer tgc_checker u_tgc_checker (.*);

`default_nettype wire

>>> tb/sv/transient_gain_computer_tb.sv
`default_nettype none

module transient_gain_computer_tb;

    localparam int CHANNELS  = tgc_pkg::NUM_CHANNELS_DEF;
    localparam int LOG_DEPTH = tgc_pkg::LOG_TABLE_DEPTH_DEF;

    localparam int Q13_ONE        = 8192;
    localparam int GAIN_CEIL      = 32768;
    localparam int GAIN_FLOOR     = 4096;
    localparam int DETAIL_LO      = 4096;
    localparam int DETAIL_HI      = 12288;
    localparam int SUSTAIN_ON     = 410;
    localparam int QUIET_LEVEL    = 4;
    localparam int ENV_BIAS       = 41;
    localparam int SUSTAIN_CUT    = 19661;
    localparam int LOG10_2_Q16    = 19728;
    localparam int LOG_SHIFT_BIAS = 9864;

    localparam logic [1:0] REG_PUNCH = 2'd0;
    localparam logic [1:0] REG_RISE  = 2'd1;
    localparam logic [1:0] REG_FALL  = 2'd2;
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 215;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 4000;

    // chan in bit 16, envelope below
    localparam bit [16:0] DIRECTED [22] = '{
        {1'b0, 16'd0},     {1'b0, 16'd4},     {1'b0, 16'd5},     {1'b0, 16'd409},
        {1'b0, 16'd410},   {1'b0, 16'd65535}, {1'b0, 16'd65535}, {1'b0, 16'd100},
        {1'b1, 16'd65535}, {1'b1, 16'd0},     {1'b1, 16'd411},   {1'b1, 16'd410},
        {1'b0, 16'd4096},  {1'b0, 16'd4097},  {1'b0, 16'd4055},  {1'b1, 16'd8151},
        {1'b1, 16'h8000},  {1'b1, 16'h7FFF},  {1'b0, 16'hAAAA},  {1'b0, 16'h5555},
        {1'b1, 16'd60000}, {1'b1, 16'd60000}
    };

    typedef struct {
        bit [15:0] gain;
        bit [13:0] detail;
    } gain_pair_t;

    class shaper_gains;
        bit [15:0]  punch;
        bit [15:0]  rise_coeff;
        bit [15:0]  fall_coeff;
        bit [15:0]  prev_env [CHANNELS];
        bit [15:0]  sustain [CHANNELS];
        bit [15:0]  log2_frac [LOG_DEPTH];
        gain_pair_t awaited [$];
        int         errors;

        function new();
            bit [63:0] y;
            bit [15:0] frac;
            for (int i = 0; i < LOG_DEPTH; i++)
            begin
                y    = (64'(LOG_DEPTH + i) << 30) / LOG_DEPTH;
                frac = '0;
                for (int b = 0; b < 16; b++)
                begin
                    y    = (y * y) >> 30;
                    frac = frac << 1;
                    if (y >= (64'd2 << 30))
                    begin
                        y       = y >> 1;
                        frac[0] = 1'b1;
                    end
                end
                log2_frac[i] = frac;
            end
            for (int c = 0; c < CHANNELS; c++)
            begin
                prev_env[c] = '0;
                sustain[c]  = '0;
            end
            punch      = '0;
            rise_coeff = '0;
            fall_coeff = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, bit [15:0] v);
            if (idx == REG_PUNCH)
                punch = v;
            else if (idx == REG_RISE)
                rise_coeff = v;
            else if (idx == REG_FALL)
                fall_coeff = v;
        endfunction

        function void note_request(bit c, bit [15:0] env);
            bit [63:0]  attack;
            bit [63:0]  s;
            bit [63:0]  cut;
            bit [63:0]  g;
            bit [63:0]  x;
            bit [63:0]  idx;
            bit [63:0]  p;
            bit [63:0]  mix;
            longint     half;
            longint     scale;
            int         k;
            int         ch;
            gain_pair_t want;
            ch = int'(c) % CHANNELS;

            attack = 64'(Q13_ONE);
            if (env > prev_env[ch])
            begin
                attack = 64'(Q13_ONE)
                         + (((64'(env) - 64'(prev_env[ch])) * punch * 20 + 16384) >> 15);
                if (attack > GAIN_CEIL)
                    attack = 64'(GAIN_CEIL);
            end
            prev_env[ch] = env;

            s = 64'(sustain[ch]);
            if (env >= SUSTAIN_ON)
            begin
                s = s + ((64'(rise_coeff) * (65536 - s) + 32768) >> 16);
                if (s > 65535)
                    s = 64'd65535;
            end
            else
                s = ((65536 - 64'(fall_coeff)) * s + 32768) >> 16;
            sustain[ch] = s[15:0];

            cut = (s * punch * SUSTAIN_CUT + (64'd1 << 34)) >> 35;
            g   = (attack * (Q13_ONE - cut) + 4096) >> 13;
            if (g > GAIN_CEIL)
                g = 64'(GAIN_CEIL);
            if (g < GAIN_FLOOR)
                g = 64'(GAIN_FLOOR);
            want.gain = g[15:0];

            if (env <= QUIET_LEVEL)
                want.detail = 14'(Q13_ONE);
            else
            begin
                x = 64'(env) + ENV_BIAS;
                k = 0;
                for (int i = 0; i < 17; i++)
                    if (x[i])
                        k = i;
                idx = ((x - (64'd1 << k)) * LOG_DEPTH) >> k;
                if (idx >= LOG_DEPTH)
                    idx = 64'(LOG_DEPTH - 1);
                // log2 of x minus 4, which stays positive since x is at least 46 here
                p     = (64'(k - 4) << 16) + log2_frac[idx];
                half  = longint'((p * LOG10_2_Q16) >> 20) - LOG_SHIFT_BIAS;
                scale = Q13_ONE - half;
                if (scale < DETAIL_LO)
                    scale = DETAIL_LO;
                if (scale > DETAIL_HI)
                    scale = DETAIL_HI;
                mix = 64'(scale) * punch + 64'(Q13_ONE) * (65536 - 64'(punch));
                want.detail = 14'((mix + 32768) >> 16);
            end
            awaited.push_back(want);
        endfunction

        function void check_result(logic [15:0] g, logic [13:0] d);
            gain_pair_t want;
            if (awaited.size() == 0)
            begin
                $error("result with no request outstanding: gain %0d detail_scale %0d", g, d);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (g !== want.gain)
            begin
                $error("gain mismatch: expected %0d, actual %0d", want.gain, g);
                errors++;
            end
            if (d !== want.detail)
            begin
                $error("detail_scale mismatch: expected %0d, actual %0d", want.detail, d);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        chan;
    logic [15:0]                 env_level;
    logic                        out_valid;
    logic                        out_stall;
    logic [15:0]                 gain;
    logic [13:0]                 detail_scale;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [tgc_pkg::ADDR_W-1:0]  paddr;
    logic [tgc_pkg::DATA_W-1:0]  pwdata;
    logic [tgc_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    shaper_gains gains = new();
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_pending;
    int          walk [CHANNELS];

    transient_gain_computer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .chan         (chan),
        .env_level    (env_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gain         (gain),
        .detail_scale (detail_scale),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // starts and ends on a falling edge
    task automatic apb_access(input bit wr, input logic [1:0] idx, input bit [31:0] wdata,
                              output bit [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input bit [15:0] v);
        bit [31:0] rd;
        apb_access(1'b1, idx, {16'h0, v}, rd);
        gains.set_reg(idx, v);
        if (idx != REG_SPARE)
        begin
            apb_access(1'b0, idx, '0, rd);
            if (rd[15:0] !== v)
            begin
                $error("register %0d readback mismatch: expected %0d, actual %0d", idx, v, rd);
                gains.errors++;
            end
        end
    endtask

    task automatic apply_coeffs(input bit [15:0] p, input bit [15:0] r, input bit [15:0] f);
        write_reg(REG_PUNCH, p);
        write_reg(REG_RISE, r);
        write_reg(REG_FALL, f);
    endtask

    // called on a falling edge, returns on a falling edge
    task automatic send_request(input bit c, input bit [15:0] e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        chan      <= c;
        env_level <= e;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        gains.note_request(c, e);
        walk[c] = int'(e);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (gains.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                gains.check_result(gain, detail_scale);
        end
    end

    // watchdog on cycles with no request or result moving
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        bit [15:0] e;
        bit        c;
        int        w;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        chan           = 1'b0;
        env_level      = '0;
        out_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pending   = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
            walk[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unmapped register is ignored
        write_reg(REG_SPARE, 16'hFFFF);
        apply_coeffs(16'd65535, 16'd30000, 16'd8000);
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        foreach (DIRECTED[i])
            send_request(DIRECTED[i][16], DIRECTED[i][15:0]);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: apply_coeffs(16'd0, 16'd0, 16'd0);
                1: apply_coeffs(16'd65535, 16'd65535, 16'd65535);
                2: apply_coeffs(16'd32768, 16'd1000, 16'd65535);
                3: apply_coeffs(16'd65535, 16'd0, 16'd0);
                default: apply_coeffs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                      16'($urandom_range(65535)));
            endcase
            if (ph < 2)
            begin
                send_idle_pct  = 8;
                recv_stall_pct = 69;
            end
            else if (ph < 4)
            begin
                send_idle_pct  = 69;
                recv_stall_pct = 8;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (ph == 1 || ph == 4)
                hold_pending = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                c = 1'($urandom_range(1));
                case ($urandom_range(9))
                    0: e = 16'($urandom_range(8));
                    1: e = 16'($urandom_range(420, 400));
                    2: e = 16'($urandom());
                    3: e = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default:
                    begin
                        // envelope-like: occasional attack jumps, otherwise slow decay
                        w = walk[c];
                        if ($urandom_range(4) == 0)
                            w = w + int'($urandom_range(30000));
                        else
                            w = w - w / 8 - int'($urandom_range(3));
                        if (w > 65535)
                            w = 65535;
                        if (w < 0)
                            w = 0;
                        e = 16'(w);
                    end
                endcase
                send_request(c, e);
            end
            drain();
        end

        if (gains.errors == 0 && gains.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/tgc_pkg.sv
rtl/transient_gain_computer.sv
rtl/tgc_checker.sv
tb/sv/transient_gain_computer_tb.sv
